// File: hdl/srg_pkg.sv
`default_nettype none

package srg_pkg;

   localparam int DATA_W      = 32;
   localparam int CHUNK_W     = 7;
   localparam int DEF_MAX_RUN = 64;

   localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(64);

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     end_of_input;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     run_last;
   } rsp_item_type;

   // per-cycle command broadcast along the cell row
   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: hdl/sorted_run_generator_top.sv
`default_nettype none

// channel    ports                          direction  handshake
// request    start, busy, req_item          in         taken when start && !busy
// response   rsp_valid, rsp_item            out        one item per cycle, no back-pressure
// config     csr_wr_en, csr_wr_data         in         written when csr_wr_en
//
// an item that does not close a run is accepted and busy stays low.
// an item that closes a run raises busy; the run of n values then streams
// out one per cycle from the head of the cell row; busy stays up until the
// row is empty. synchronous reset empties the row and sets chunk size to 64.
// the receiver cannot stall the response channel.

module sorted_run_generator_top #(
   parameter int MAX_RUN = srg_pkg::DEF_MAX_RUN
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire srg_pkg::req_item_type         req_item,
   output logic                               rsp_valid,
   output srg_pkg::rsp_item_type              rsp_item,
   input  wire logic                          csr_wr_en,
   input  wire logic [srg_pkg::CHUNK_W-1:0]   csr_wr_data
);
   import srg_pkg::*;

   localparam int FILL_W = $clog2(MAX_RUN + 1);

   logic [CHUNK_W-1:0]   chunk_ff;
   logic [FILL_W-1:0]    fill_ff;
   logic [FILL_W-1:0]    fill_in;
   logic                 drain_ff;
   logic                 drain_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_item_type         rsp_item_ff;
   rsp_item_type         rsp_item_in;

   logic                 accept;
   logic                 flush;
   logic [CHUNK_W-1:0]   chunk_eff;
   logic [CHUNK_W-1:0]   fill_next;
   cell_ctl_type         ctl;

   logic signed [DATA_W-1:0] cell_value [MAX_RUN];
   logic                     cell_valid [MAX_RUN];
   logic                     cell_gt    [MAX_RUN];

   assign accept = start && !drain_ff;
   assign busy   = drain_ff;

   always_comb begin
      priority if (chunk_ff == '0) begin
         chunk_eff = CHUNK_W'(1);
      end else if (chunk_ff > CHUNK_W'(MAX_RUN)) begin
         chunk_eff = CHUNK_W'(MAX_RUN);
      end else begin
         chunk_eff = chunk_ff;
      end
   end

   assign fill_next = CHUNK_W'(fill_ff) + CHUNK_W'(1);
   assign flush     = (fill_next >= chunk_eff) || req_item.end_of_input;

   assign ctl.insert = accept;
   assign ctl.drain  = drain_ff;

   genvar i;
   generate
      for (i = 0; i < MAX_RUN; i++) begin : g_cell
         logic signed [DATA_W-1:0] l_value;
         logic                     l_valid;
         logic                     l_gt;
         logic signed [DATA_W-1:0] r_value;
         logic                     r_valid;

         if (i == 0) begin : g_head
            assign l_value = req_item.value;
            assign l_valid = 1'b1;
            assign l_gt    = 1'b0;
         end else begin : g_body
            assign l_value = cell_value[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_gt    = cell_gt[i-1];
         end

         if (i == MAX_RUN - 1) begin : g_tail
            assign r_value = cell_value[i];
            assign r_valid = 1'b0;
         end else begin : g_inner
            assign r_value = cell_value[i+1];
            assign r_valid = cell_valid[i+1];
         end

         srg_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .new_value   (req_item.value),
            .left_value  (l_value),
            .left_valid  (l_valid),
            .left_gt     (l_gt),
            .right_value (r_value),
            .right_valid (r_valid),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .gt          (cell_gt[i])
         );
      end
   endgenerate

   always_comb begin
      fill_in      = fill_ff;
      drain_in     = drain_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      if (drain_ff) begin
         // head of the row leaves each cycle
         rsp_valid_in             = 1'b1;
         rsp_item_in.sorted_value = cell_value[0];
         rsp_item_in.run_last     = (fill_ff == FILL_W'(1));
         fill_in                  = fill_ff - FILL_W'(1);
         drain_in                 = (fill_ff != FILL_W'(1));
      end else if (accept) begin
         fill_in  = fill_ff + FILL_W'(1);
         drain_in = flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff     <= CHUNK_RESET;
         fill_ff      <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            chunk_ff <= csr_wr_data;
         end
         fill_ff      <= fill_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

// File: hdl/srg_cell.sv
`default_nettype none

module srg_cell (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire srg_pkg::cell_ctl_type                ctl,
   input  wire logic signed [srg_pkg::DATA_W-1:0]    new_value,
   input  wire logic signed [srg_pkg::DATA_W-1:0]    left_value,
   input  wire logic                                 left_valid,
   input  wire logic                                 left_gt,
   input  wire logic signed [srg_pkg::DATA_W-1:0]    right_value,
   input  wire logic                                 right_valid,
   output logic signed [srg_pkg::DATA_W-1:0]         value,
   output logic                                      valid,
   output logic                                      gt
);
   import srg_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic                     valid_ff;
   logic                     valid_in;
   logic                     take;

   // strict compare keeps equal values in arrival order
   assign gt = valid_ff && (value_ff > new_value);

   // a larger entry moves right; the first empty cell after the fill takes one too
   assign take = gt || (!valid_ff && left_valid);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.drain) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (ctl.insert && take) begin
         value_in = left_gt ? left_value : new_value;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire
